// ===== src/rfcs_pkg.sv =====
// Shared constants and types of the ring fit chi-square block.
package rfcs_pkg;

  localparam int MAX_HITS   = 255;
  localparam int CNT_W      = $clog2(MAX_HITS + 1);
  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int ABS_W      = COORD_W;
  localparam int SQSUM_W    = 2 * ABS_W + 2;
  localparam int ROOT_W     = SQSUM_W / 2;
  localparam int REM_W      = ROOT_W + 4;
  localparam int ITER_W     = $clog2(ROOT_W);
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int SUM_W      = 48;
  localparam int DIV_STEP_W = $clog2(SUM_W);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int MIN_HITS   = 4;
  localparam int DOF_LOSS   = 3;
  localparam int IN_DATA_W  = 5 * COORD_W;

  // one hit as seen by the back end
  typedef struct packed {
    logic [ABS_W-1:0]   ax;
    logic [ABS_W-1:0]   ay;
    logic [COORD_W-1:0] radius;
    logic               last;
  } hit_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/ring_fit_chi_square.sv =====
// Top level of the ring fit chi-square block.
//
// Hits of one fitted ring arrive one beat at a time; the beat with tlast
// closes the ring and yields one result beat. The back end squares the
// differences and adds them, then the square root unit resolves one of 17
// root bits per cycle, then the residual is squared and added to the sum;
// it takes the next hit only once it is through with the last one. The
// closing hit of a ring with at least four hits then runs the bit-serial
// divider. A four-entry queue and a register stage in front let up to five
// hits be taken while the back end is busy or a result beat is waiting.
// out_tuser is 0 for rings with fewer than four hits, and chi_square is 0.
module ring_fit_chi_square (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // hit_x[15:0], hit_y[31:16], center_x[47:32], center_y[63:48],
  // ring_radius[79:64]
  input  logic [79:0] in_tdata,
  input  logic        in_tlast,   // last_hit
  output logic        out_tvalid,
  input  logic        out_tready,
  // chi_square[47:0]
  output logic [47:0] out_tdata,
  // fit_valid[0]
  output logic        out_tuser
);

  logic           push;
  logic           push_ready;
  rfcs_pkg::hit_t push_data;
  logic           pop;
  logic           pop_valid;
  rfcs_pkg::hit_t pop_data;

  rfcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  rfcs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (push_data),
    .wr_ready (push_ready),
    .rd_en    (pop),
    .rd_data  (pop_data),
    .rd_valid (pop_valid)
  );

  rfcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .hit_valid  (pop_valid),
    .hit        (pop_data),
    .hit_pop    (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== src/rfcs_front.sv =====
// Front end: accepts hit beats and forms absolute coordinate differences.
module rfcs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rfcs_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tlast,
  output logic                          push,
  output rfcs_pkg::hit_t                push_data,
  input  logic                          push_ready
);

  logic signed [rfcs_pkg::DIFF_W-1:0] dx;
  logic signed [rfcs_pkg::DIFF_W-1:0] dy;
  logic signed [rfcs_pkg::DIFF_W-1:0] ndx;
  logic signed [rfcs_pkg::DIFF_W-1:0] ndy;
  logic                               vld_r;
  rfcs_pkg::hit_t                     hit_r;
  rfcs_pkg::hit_t                     hit_nxt;
  logic                               take;

  // center minus hit, sign-extended by one bit
  always_comb begin
    dx  = $signed({in_tdata[47], in_tdata[47:32]}) - $signed({in_tdata[15], in_tdata[15:0]});
    dy  = $signed({in_tdata[63], in_tdata[63:48]}) - $signed({in_tdata[31], in_tdata[31:16]});
    ndx = -dx;
    ndy = -dy;
    hit_nxt.ax     = dx[rfcs_pkg::DIFF_W-1] ? ndx[rfcs_pkg::ABS_W-1:0] : dx[rfcs_pkg::ABS_W-1:0];
    hit_nxt.ay     = dy[rfcs_pkg::DIFF_W-1] ? ndy[rfcs_pkg::ABS_W-1:0] : dy[rfcs_pkg::ABS_W-1:0];
    hit_nxt.radius = in_tdata[79:64];
    hit_nxt.last   = in_tlast;
  end

  assign push      = vld_r;
  assign push_data = hit_r;
  assign in_tready = !vld_r || push_ready;
  assign take      = in_tvalid && in_tready;

  // hold one classified hit until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (push_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

// ===== src/rfcs_fifo.sv =====
// Short hit queue between the front end and the back end.
module rfcs_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  rfcs_pkg::hit_t wr_data,
  output logic           wr_ready,
  input  logic           rd_en,
  output rfcs_pkg::hit_t rd_data,
  output logic           rd_valid
);

  rfcs_pkg::hit_t                  mem_r [rfcs_pkg::FIFO_DEPTH];
  logic [rfcs_pkg::FIFO_AW-1:0]    wr_ptr_r;
  logic [rfcs_pkg::FIFO_AW-1:0]    rd_ptr_r;
  logic [rfcs_pkg::FIFO_AW:0]      cnt_r;
  logic                            do_wr;
  logic                            do_rd;

  assign wr_ready = (cnt_r != (rfcs_pkg::FIFO_AW + 1)'(rfcs_pkg::FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/rfcs_div.sv =====
// Restoring divider, one quotient bit per cycle.
module rfcs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rfcs_pkg::div_req_t req,
  output rfcs_pkg::div_rsp_t rsp
);

  logic                               busy_r;
  logic                               done_r;
  logic [rfcs_pkg::DIV_STEP_W-1:0]    step_r;
  logic [rfcs_pkg::SUM_W-1:0]         quo_r;
  logic [rfcs_pkg::CNT_W-1:0]         rem_r;
  logic [rfcs_pkg::CNT_W-1:0]         dsr_r;
  logic [rfcs_pkg::CNT_W:0]           shifted;
  logic [rfcs_pkg::CNT_W:0]           diff;
  logic                               ge;

  // shift in the next dividend bit and trial-subtract
  always_comb begin
    shifted = {rem_r, quo_r[rfcs_pkg::SUM_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    ge      = (shifted >= {1'b0, dsr_r});
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == rfcs_pkg::DIV_STEP_W'(rfcs_pkg::SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[rfcs_pkg::SUM_W-2:0], ge};
      rem_r <= ge ? diff[rfcs_pkg::CNT_W-1:0] : shifted[rfcs_pkg::CNT_W-1:0];
    end
  end

endmodule

// ===== src/rfcs_back.sv =====
// Back end: distance root, squared residual, ring sum and result.
module rfcs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          hit_valid,
  input  rfcs_pkg::hit_t                hit,
  output logic                          hit_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rfcs_pkg::SUM_W-1:0]    out_tdata,
  output logic                          out_tuser
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]                       state_r;
  logic [2:0]                       state_nxt;
  rfcs_pkg::hit_t                   hit_r;
  logic [2*rfcs_pkg::ABS_W-1:0]     sx_r;
  logic [2*rfcs_pkg::ABS_W-1:0]     sy_r;
  logic [rfcs_pkg::SQSUM_W-1:0]     v_r;
  logic [rfcs_pkg::REM_W-1:0]       rem_r;
  logic [rfcs_pkg::ROOT_W-1:0]      root_r;
  logic [rfcs_pkg::ITER_W-1:0]      iter_r;
  logic [rfcs_pkg::SQ_W-1:0]        sq_r;
  logic [rfcs_pkg::SUM_W-1:0]       sum_r;
  logic [rfcs_pkg::CNT_W-1:0]       cnt_r;
  logic [rfcs_pkg::SUM_W-1:0]       out_data_r;
  logic                             out_user_r;
  logic [rfcs_pkg::REM_W-1:0]       rem_sh;
  logic [rfcs_pkg::REM_W-1:0]       trial;
  logic                             fits;
  logic [rfcs_pkg::ROOT_W-1:0]      rad_ext;
  logic [rfcs_pkg::ROOT_W-1:0]      ad;
  logic [rfcs_pkg::SUM_W:0]         sum_wide;
  logic [rfcs_pkg::SUM_W-1:0]       sum_new;
  logic [rfcs_pkg::CNT_W-1:0]       cnt_new;
  logic                             enough;
  rfcs_pkg::div_req_t               div_req;
  rfcs_pkg::div_rsp_t               div_rsp;

  rfcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // one root digit: bring down two bits and trial-subtract
  always_comb begin
    rem_sh = {rem_r[rfcs_pkg::REM_W-3:0], v_r[rfcs_pkg::SQSUM_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // residual magnitude and saturating ring sum
  always_comb begin
    rad_ext  = {1'b0, hit_r.radius};
    ad       = (root_r >= rad_ext) ? (root_r - rad_ext) : (rad_ext - root_r);
    sum_wide = {1'b0, sum_r} + (rfcs_pkg::SUM_W + 1)'(sq_r);
    sum_new  = sum_wide[rfcs_pkg::SUM_W] ? '1 : sum_wide[rfcs_pkg::SUM_W-1:0];
    cnt_new  = (cnt_r < rfcs_pkg::CNT_W'(rfcs_pkg::MAX_HITS)) ? cnt_r + 1'b1 : cnt_r;
    enough   = (cnt_new >= rfcs_pkg::CNT_W'(rfcs_pkg::MIN_HITS));
  end

  always_comb begin
    div_req.start    = (state_r == S_ACC) && hit_r.last && enough;
    div_req.dividend = sum_new;
    div_req.divisor  = cnt_new - rfcs_pkg::CNT_W'(rfcs_pkg::DOF_LOSS);
  end

  assign hit_pop    = (state_r == S_IDLE) && hit_valid;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // sequence one hit through the shared units
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (hit_valid) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ADD;
      S_ADD:  state_nxt = S_ROOT;
      S_ROOT: if (iter_r == rfcs_pkg::ITER_W'(rfcs_pkg::ROOT_W - 1)) state_nxt = S_RES;
      S_RES:  state_nxt = S_ACC;
      S_ACC: begin
        if (!hit_r.last) begin
          state_nxt = S_IDLE;
        end else if (enough) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV:  if (div_rsp.done) state_nxt = S_OUT;
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ACC) begin
        if (hit_r.last) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_new;
          cnt_r <= cnt_new;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (hit_pop) begin
      hit_r <= hit;
    end
    if (state_r == S_SQ) begin
      sx_r <= hit_r.ax * hit_r.ax;
      sy_r <= hit_r.ay * hit_r.ay;
    end
    if (state_r == S_ADD) begin
      v_r    <= rfcs_pkg::SQSUM_W'(sx_r) + rfcs_pkg::SQSUM_W'(sy_r);
      rem_r  <= '0;
      root_r <= '0;
      iter_r <= '0;
    end
    if (state_r == S_ROOT) begin
      v_r    <= {v_r[rfcs_pkg::SQSUM_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[rfcs_pkg::ROOT_W-2:0], fits};
      iter_r <= iter_r + 1'b1;
    end
    if (state_r == S_RES) begin
      sq_r <= ad * ad;
    end
    if ((state_r == S_ACC) && hit_r.last && !enough) begin
      out_data_r <= '0;
      out_user_r <= 1'b0;
    end
    if ((state_r == S_DIV) && div_rsp.done) begin
      out_data_r <= div_rsp.quotient;
      out_user_r <= 1'b1;
    end
  end

endmodule

// ===== verif/ring_fit_chi_square_tb.sv =====
// Self-checking testbench of the ring fit chi-square block: predictor, stimulus and checks.
module testbench;

  localparam logic [rfcs_pkg::SUM_W-1:0] SUM_MAX     = {rfcs_pkg::SUM_W{1'b1}};
  localparam int                         CYCLE_LIMIT = 4_000_000;
  localparam int                         TAIL_CYCLES = 200;
  localparam int                         RANDOM_HITS = 720;

  // one hit beat as the sender sees it
  typedef struct {
    logic signed [rfcs_pkg::COORD_W-1:0] hx;
    logic signed [rfcs_pkg::COORD_W-1:0] hy;
    logic signed [rfcs_pkg::COORD_W-1:0] cx;
    logic signed [rfcs_pkg::COORD_W-1:0] cy;
    logic [rfcs_pkg::COORD_W-1:0]        radius;
    logic                                last;
  } hit_beat_t;

  // one fit result beat
  typedef struct {
    logic [rfcs_pkg::SUM_W-1:0] chi_square;
    logic                       fit_valid;
  } fit_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;

  ring_fit_chi_square i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // predictor state of the ring in progress
  logic [rfcs_pkg::SUM_W-1:0] ring_sq_sum;
  int unsigned                ring_hits;

  fit_result_t pending_fits[$];
  int          fail_count;
  int          ring_count;
  int          hit_total;
  int          valid_count;
  int          cycle_count;
  int          ready_hold;
  bit          idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor square root, one root bit tried per step from the top
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // distance from hit to ring center, truncated to whole units
  function automatic logic [63:0] hit_distance(input hit_beat_t h);
    longint dx;
    longint dy;
    dx = longint'(h.cx) - longint'(h.hx);
    dy = longint'(h.cy) - longint'(h.hy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return floor_root(64'(dx * dx + dy * dy));
  endfunction

  // fold one accepted hit into the ring sums; queue a result on the closing hit
  task automatic fold_hit(input hit_beat_t h);
    logic [63:0] hit_dist;
    logic [63:0] resid;
    logic [63:0] sq;
    logic [63:0] quo;
    fit_result_t r;
    hit_dist = hit_distance(h);
    resid = (hit_dist >= 64'(h.radius)) ? hit_dist - 64'(h.radius)
                                        : 64'(h.radius) - hit_dist;
    sq    = resid * resid;
    if (sq > 64'(SUM_MAX - ring_sq_sum)) ring_sq_sum = SUM_MAX;
    else ring_sq_sum = ring_sq_sum + sq[rfcs_pkg::SUM_W-1:0];
    if (ring_hits < rfcs_pkg::MAX_HITS) ring_hits++;
    hit_total++;
    if (h.last) begin
      if (ring_hits < rfcs_pkg::MIN_HITS) begin
        r.chi_square = '0;
        r.fit_valid  = 1'b0;
      end else begin
        quo          = 64'(ring_sq_sum) / 64'(ring_hits - rfcs_pkg::DOF_LOSS);
        r.chi_square = quo[rfcs_pkg::SUM_W-1:0];
        r.fit_valid  = 1'b1;
        valid_count++;
      end
      pending_fits.push_back(r);
      ring_count++;
      ring_sq_sum = '0;
      ring_hits   = 0;
    end
  endtask

  // send one hit beat; tvalid stays high into the next beat when no gap is drawn
  task automatic send_hit(input logic [15:0] hx, input logic [15:0] hy,
                          input logic [15:0] cx, input logic [15:0] cy,
                          input logic [15:0] radius, input logic last);
    int        gap;
    hit_beat_t h;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    h.hx     = hx;
    h.hy     = hy;
    h.cx     = cx;
    h.cy     = cy;
    h.radius = radius;
    h.last   = last;
    in_tvalid <= 1'b1;
    in_tdata  <= {radius, cy, cx, hy, hx};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    fold_hit(h);
  endtask

  // drop tvalid and hold until every queued result has come back
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // pick a field value, leaning on the extremes
  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  // rings of one to five hits, extreme offsets and exact circle hits
  task automatic test_short_rings;
    idle_on = 1'b1;
    send_hit(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff, 1'b1);
    send_hit(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    send_hit(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b1);
    send_hit(16'd300, 16'd400, 16'h0000, 16'h0000, 16'd500, 1'b0);
    send_hit(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'd1, 1'b0);
    send_hit(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 1'b1);
    // four hits: largest residual, center on hit, opposite corners, exact circle
    send_hit(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    send_hit(16'h1234, 16'hedcb, 16'h1234, 16'hedcb, 16'hffff, 1'b0);
    send_hit(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff, 1'b0);
    send_hit(16'd300, 16'd400, 16'h0000, 16'h0000, 16'd500, 1'b1);
    // five hits on a circle of radius 5: zero chi-square, valid fit
    send_hit(16'd3, 16'd4, 16'd0, 16'd0, 16'd5, 1'b0);
    send_hit(16'hfffd, 16'd4, 16'd0, 16'd0, 16'd5, 1'b0);
    send_hit(16'd4, 16'hfffd, 16'd0, 16'd0, 16'd5, 1'b0);
    send_hit(16'd0, 16'd5, 16'd0, 16'd0, 16'd5, 1'b0);
    send_hit(16'hfffb, 16'd0, 16'd0, 16'd0, 16'd5, 1'b1);
    // four all-zero hits, no idling
    idle_on = 1'b0;
    for (int i = 0; i < 4; i++)
      send_hit(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, i == 3);
    drain();
  endtask

  // one long ring so the hit counter stops at its ceiling
  task automatic test_count_ceiling;
    logic [15:0] cx;
    logic [15:0] cy;
    cx = 16'($urandom());
    cy = 16'($urandom());
    idle_on = 1'b1;
    for (int i = 0; i < 300; i++)
      send_hit(16'(cx + $urandom_range(0, 2000)), 16'(cy - $urandom_range(0, 2000)),
               cx, cy, 16'($urandom_range(0, 3000)), i == 299);
    drain();
  endtask

  // random rings: mostly hits near a fitted circle, some extremes and noise
  task automatic test_random_rings;
    int          sent;
    int          ring_len;
    int          flavor;
    logic [15:0] cx;
    logic [15:0] cy;
    hit_beat_t   h;
    longint      rad;
    sent = 0;
    while (sent < RANDOM_HITS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 19))
        0:       ring_len = $urandom_range(13, 40);
        1, 2:    ring_len = $urandom_range(1, 3);
        default: ring_len = $urandom_range(4, 12);
      endcase
      cx = 16'($urandom());
      cy = 16'($urandom());
      for (int i = 0; i < ring_len; i++) begin
        flavor = $urandom_range(0, 9);
        if (flavor < 6) begin
          // near a circle around the ring center, radius close to the distance
          h.cx = cx;
          h.cy = cy;
          h.hx = 16'(cx + $urandom_range(0, 4000) - 2000);
          h.hy = 16'(cy + $urandom_range(0, 4000) - 2000);
          rad  = longint'(hit_distance(h)) + $urandom_range(0, 16) - 8;
          if (rad < 0) rad = 0;
          h.radius = 16'(rad);
        end else if (flavor < 8) begin
          h.hx = pick_field();
          h.hy = pick_field();
          h.cx = pick_field();
          h.cy = pick_field();
          h.radius = pick_field();
        end else begin
          h.hx = 16'($urandom());
          h.hy = 16'($urandom());
          h.cx = 16'($urandom());
          h.cy = 16'($urandom());
          h.radius = 16'($urandom());
        end
        send_hit(h.hx, h.hy, h.cx, h.cy, h.radius, i == ring_len - 1);
        sent++;
      end
    end
    drain();
  endtask

  // check each result beat and stall the result side at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_fits.size() == 0) begin
        $error("unexpected result beat: chi_square %0d fit_valid %0b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        fit_result_t want;
        want = pending_fits.pop_front();
        if (out_tdata !== want.chi_square) begin
          $error("chi_square: expected %0d, got %0d", want.chi_square, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.fit_valid) begin
          $error("fit_valid: expected %0b, got %0b", want.fit_valid, out_tuser);
          fail_count++;
        end
      end
      ready_hold = idle_on ? $urandom_range(0, 3) : 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end
    out_tready <= (ready_hold == 0);
  end

  // end the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    fail_count  = 0;
    ring_count  = 0;
    hit_total   = 0;
    valid_count = 0;
    cycle_count = 0;
    ready_hold  = 0;
    idle_on     = 1'b0;
    ring_sq_sum = '0;
    ring_hits   = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_rings();
    test_count_ceiling();
    test_random_rings();

    $display("tb: %0d hits in %0d rings checked, %0d valid fits", hit_total, ring_count,
             valid_count);
    $display("tb: short rings, count ceiling and random rings with stalls on both sides");
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== ring_fit_chi_square.f =====
src/rfcs_pkg.sv
src/rfcs_front.sv
src/rfcs_fifo.sv
src/rfcs_div.sv
src/rfcs_back.sv
src/ring_fit_chi_square.sv
verif/ring_fit_chi_square_tb.sv
